### rtl/qau_pkg.sv
// Shared types, constants and the arctangent lookup table for the quaternion attitude update block.
`default_nettype none
package qau_pkg;

  localparam int QUAT_W  = 32;
  localparam int GYRO_W  = 16;
  localparam int ANGLE_W = 32;
  localparam int SCALE_W = 32;
  localparam int QF      = QUAT_W - 2;
  localparam int NW      = QUAT_W + 4;
  localparam int MW      = QUAT_W + 1;
  localparam int PW      = 2 * MW;
  localparam int TW      = QUAT_W + 2;
  localparam int CW      = QUAT_W + 6;
  localparam int SW      = 64;
  localparam int CNT_W   = 5;

  localparam logic [SCALE_W-1:0]       SCALE_RESET = 32'd216930;
  localparam logic signed [QUAT_W-1:0] Q_ONE       = 32'sh4000_0000;

  localparam logic [CNT_W-1:0] N_GYRO     = 5'd3;
  localparam logic [CNT_W-1:0] N_UPD      = 5'd12;
  localparam logic [CNT_W-1:0] N_SQSUM    = 5'd4;
  localparam logic [CNT_W-1:0] N_DCM      = 5'd10;
  localparam logic [CNT_W-1:0] N_TSQ      = 5'd1;
  localparam logic [CNT_W-1:0] SQRT_LAST  = 5'd31;
  localparam logic [CNT_W-1:0] DIV_LAST   = 5'd30;
  localparam logic [CNT_W-1:0] CORD_LAST  = 5'd30;

  typedef enum logic [4:0] {
    ST_IDLE, ST_GYRO, ST_UPD, ST_HALVE, ST_SQSUM, ST_NCHK, ST_SQRT1, ST_DIVI,
    ST_DIV, ST_QST, ST_DCM, ST_TSQ, ST_SQRT2I, ST_SQRT2, ST_CORDI, ST_CORD, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_GYRO, OP_UPD, OP_HALVE, OP_SQSUM, OP_IDENT, OP_SQRT_INIT,
    OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_QSTORE, OP_DCM, OP_TSQ,
    OP_CORD_INIT, OP_CORD_STEP, OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic             mul_en;
    logic [CNT_W-1:0] idx;
    logic             sel;
  } dp_cmd_t;

  typedef struct packed {
    logic big;
    logic norm_zero;
  } dp_status_t;

  // Arctangent of 2^-i as a binary angle with pi at 2^31.
  function automatic logic [ANGLE_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [ANGLE_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/qau_ctrl.sv
// Sequencing state machine for the quaternion attitude update block.
`default_nettype none
module qau_ctrl import qau_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_load;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 5'd1;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) state_d = ST_GYRO;
      end
      ST_GYRO:   if (cnt_q == N_GYRO) begin state_d = ST_UPD; cnt_d = '0; end
      ST_UPD:    if (cnt_q == N_UPD) begin state_d = ST_HALVE; cnt_d = '0; end
      ST_HALVE: begin
        cnt_d = '0;
        if (!status_i.big) state_d = ST_SQSUM;
      end
      ST_SQSUM:  if (cnt_q == N_SQSUM) begin state_d = ST_NCHK; cnt_d = '0; end
      ST_NCHK: begin
        cnt_d   = '0;
        state_d = status_i.norm_zero ? ST_DCM : ST_SQRT1;
      end
      ST_SQRT1:  if (cnt_q == SQRT_LAST) begin state_d = ST_DIVI; cnt_d = '0; end
      ST_DIVI: begin state_d = ST_DIV; cnt_d = '0; end
      ST_DIV:    if (cnt_q == DIV_LAST) begin state_d = ST_QST; cnt_d = '0; end
      ST_QST: begin state_d = ST_DCM; cnt_d = '0; end
      ST_DCM:    if (cnt_q == N_DCM) begin state_d = ST_TSQ; cnt_d = '0; end
      ST_TSQ:    if (cnt_q == N_TSQ) begin state_d = ST_SQRT2I; cnt_d = '0; end
      ST_SQRT2I: begin state_d = ST_SQRT2; cnt_d = '0; end
      ST_SQRT2:  if (cnt_q == SQRT_LAST) begin state_d = ST_CORDI; cnt_d = '0; end
      ST_CORDI: begin state_d = ST_CORD; cnt_d = '0; end
      ST_CORD:   if (cnt_q == CORD_LAST) begin state_d = ST_DONE; cnt_d = '0; end
      ST_DONE: begin
        cnt_d = '0;
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: begin state_d = ST_IDLE; cnt_d = '0; end
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.idx    = cnt_q;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE:   if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_GYRO: begin
        cmd_o.op     = OP_GYRO;
        cmd_o.mul_en = (cnt_q < N_GYRO);
      end
      ST_UPD: begin
        cmd_o.op     = OP_UPD;
        cmd_o.mul_en = (cnt_q < N_UPD);
      end
      ST_HALVE:  if (status_i.big) cmd_o.op = OP_HALVE;
      ST_SQSUM: begin
        cmd_o.op     = OP_SQSUM;
        cmd_o.mul_en = (cnt_q < N_SQSUM);
      end
      ST_NCHK:   cmd_o.op = status_i.norm_zero ? OP_IDENT : OP_SQRT_INIT;
      ST_SQRT1:  cmd_o.op = OP_SQRT_STEP;
      ST_DIVI:   cmd_o.op = OP_DIV_INIT;
      ST_DIV:    cmd_o.op = OP_DIV_STEP;
      ST_QST:    cmd_o.op = OP_QSTORE;
      ST_DCM: begin
        cmd_o.op     = OP_DCM;
        cmd_o.mul_en = (cnt_q < N_DCM);
      end
      ST_TSQ: begin
        cmd_o.op     = OP_TSQ;
        cmd_o.mul_en = (cnt_q < N_TSQ);
      end
      ST_SQRT2I: begin
        cmd_o.op  = OP_SQRT_INIT;
        cmd_o.sel = 1'b1;
      end
      ST_SQRT2:  cmd_o.op = OP_SQRT_STEP;
      ST_CORDI:  cmd_o.op = OP_CORD_INIT;
      ST_CORD:   cmd_o.op = OP_CORD_STEP;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_OUT;
          out_load = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || out_load;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result load did not raise out_valid");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_GYRO))
    else $error("accepted item did not start the scaling phase");

  a_halve_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HALVE && !status_i.big) |=> (state_q == ST_SQSUM))
    else $error("halving loop did not exit when components fit");

endmodule
`default_nettype wire

### rtl/qau_dp.sv
// Datapath: shared multiplier, square root, divider lanes and CORDIC lanes.
`default_nettype none
module qau_dp import qau_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SCALE_W-1:0]        cfg_wdata_i,
  input  logic signed [GYRO_W-1:0]  rate_x_i,
  input  logic signed [GYRO_W-1:0]  rate_y_i,
  input  logic signed [GYRO_W-1:0]  rate_z_i,
  input  dp_cmd_t                   cmd_i,
  output dp_status_t                status_o,
  output logic signed [QUAT_W-1:0]  quat_w_o,
  output logic signed [QUAT_W-1:0]  quat_x_o,
  output logic signed [QUAT_W-1:0]  quat_y_o,
  output logic signed [QUAT_W-1:0]  quat_z_o,
  output logic signed [ANGLE_W-1:0] yaw_angle_o,
  output logic signed [ANGLE_W-1:0] pitch_angle_o,
  output logic signed [ANGLE_W-1:0] roll_angle_o
);

  localparam logic signed [PW-1:0] QMAX_P = 66'sd2147483647;
  localparam logic signed [NW-1:0] QMAX_N = 36'sd2147483647;
  localparam logic signed [TW-1:0] ONE_T  = 34'sd1073741824;
  localparam logic signed [32:0]   ONE_P  = 33'sd1073741824;
  localparam logic [SW-1:0]        ONE_SQ = 64'h1000_0000_0000_0000;

  logic [SCALE_W-1:0]       scale_q;
  logic signed [GYRO_W-1:0] rate_q [3];
  logic signed [QUAT_W-1:0] h_q [3];
  logic signed [NW-1:0]     n_q [4];
  logic signed [QUAT_W-1:0] q_q [4];
  logic [SW-1:0]            s_q, sv_q, sr_q, src2_q;
  logic [32:0]              rem_q [4];
  logic [30:0]              quo_q [4];
  logic signed [QUAT_W-1:0] p_q [10];
  logic signed [CW-1:0]     cx_q [3], cy_q [3];
  logic [ANGLE_W-1:0]       cz_q [3];
  logic                     czero_q [3];
  logic signed [PW-1:0]     prod_q;
  dp_op_e                   pop_q;
  logic [CNT_W-1:0]         pidx_q;
  logic                     pvld_q;

  logic signed [MW-1:0]     ma, mb;
  logic signed [PW-1:0]     gsh, qsh;
  logic signed [NW-1:0]     qm;
  logic signed [TW-1:0]     t11, t12, t13, t23, t33;
  logic signed [QUAT_W-1:0] tc;
  logic [5:0]               sh;
  logic [SW-1:0]            sbit, rsum;
  logic [32:0]              r33;
  logic [1:0]               utgt;
  logic                     uneg;
  logic signed [CW-1:0]     lx [3], ly [3];
  logic [ANGLE_W-1:0]       pz;
  logic signed [32:0]       pneg;
  logic signed [QUAT_W-1:0] pitch_c;

  // Multiplier operand selection.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_GYRO: begin
        mb = $signed({1'b0, scale_q});
        case (cmd_i.idx)
          5'd0:    ma = MW'(rate_q[0]);
          5'd1:    ma = MW'(rate_q[1]);
          default: ma = MW'(rate_q[2]);
        endcase
      end
      OP_UPD: begin
        case (cmd_i.idx)
          5'd0:    begin ma = MW'(q_q[1]); mb = MW'(h_q[0]); end
          5'd1:    begin ma = MW'(q_q[2]); mb = MW'(h_q[1]); end
          5'd2:    begin ma = MW'(q_q[3]); mb = MW'(h_q[2]); end
          5'd3:    begin ma = MW'(q_q[0]); mb = MW'(h_q[0]); end
          5'd4:    begin ma = MW'(q_q[2]); mb = MW'(h_q[2]); end
          5'd5:    begin ma = MW'(q_q[3]); mb = MW'(h_q[1]); end
          5'd6:    begin ma = MW'(q_q[0]); mb = MW'(h_q[1]); end
          5'd7:    begin ma = MW'(q_q[1]); mb = MW'(h_q[2]); end
          5'd8:    begin ma = MW'(q_q[3]); mb = MW'(h_q[0]); end
          5'd9:    begin ma = MW'(q_q[0]); mb = MW'(h_q[2]); end
          5'd10:   begin ma = MW'(q_q[1]); mb = MW'(h_q[1]); end
          default: begin ma = MW'(q_q[2]); mb = MW'(h_q[0]); end
        endcase
      end
      OP_SQSUM: begin
        case (cmd_i.idx)
          5'd0:    ma = n_q[0][MW-1:0];
          5'd1:    ma = n_q[1][MW-1:0];
          5'd2:    ma = n_q[2][MW-1:0];
          default: ma = n_q[3][MW-1:0];
        endcase
        mb = ma;
      end
      OP_DCM: begin
        case (cmd_i.idx)
          5'd0:    begin ma = MW'(q_q[0]); mb = MW'(q_q[0]); end
          5'd1:    begin ma = MW'(q_q[0]); mb = MW'(q_q[1]); end
          5'd2:    begin ma = MW'(q_q[0]); mb = MW'(q_q[2]); end
          5'd3:    begin ma = MW'(q_q[0]); mb = MW'(q_q[3]); end
          5'd4:    begin ma = MW'(q_q[1]); mb = MW'(q_q[1]); end
          5'd5:    begin ma = MW'(q_q[1]); mb = MW'(q_q[2]); end
          5'd6:    begin ma = MW'(q_q[1]); mb = MW'(q_q[3]); end
          5'd7:    begin ma = MW'(q_q[2]); mb = MW'(q_q[2]); end
          5'd8:    begin ma = MW'(q_q[2]); mb = MW'(q_q[3]); end
          default: begin ma = MW'(q_q[3]); mb = MW'(q_q[3]); end
        endcase
      end
      OP_TSQ: begin
        ma = MW'(tc);
        mb = MW'(tc);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Sign and target of each term in the first-order update.
  always_comb begin
    case (pidx_q)
      5'd0, 5'd1, 5'd2: begin utgt = 2'd0; uneg = 1'b1; end
      5'd3, 5'd4:       begin utgt = 2'd1; uneg = 1'b0; end
      5'd5:             begin utgt = 2'd1; uneg = 1'b1; end
      5'd6, 5'd8:       begin utgt = 2'd2; uneg = 1'b0; end
      5'd7:             begin utgt = 2'd2; uneg = 1'b1; end
      5'd9, 5'd10:      begin utgt = 2'd3; uneg = 1'b0; end
      default:          begin utgt = 2'd3; uneg = 1'b1; end
    endcase
  end

  always_comb begin
    gsh = prod_q >>> 3;
    qsh = prod_q >>> QF;
    qm  = qsh[NW-1:0];
    t11 = TW'(p_q[0]) + TW'(p_q[4]) - TW'(p_q[7]) - TW'(p_q[9]);
    t12 = (TW'(p_q[5]) + TW'(p_q[3])) <<< 1;
    t13 = (TW'(p_q[6]) - TW'(p_q[2])) <<< 1;
    t23 = (TW'(p_q[8]) + TW'(p_q[1])) <<< 1;
    t33 = TW'(p_q[0]) - TW'(p_q[4]) - TW'(p_q[7]) + TW'(p_q[9]);
    if (t13 > ONE_T) tc = Q_ONE;
    else if (t13 < -ONE_T) tc = -Q_ONE;
    else tc = t13[QUAT_W-1:0];
    sh   = 6'd62 - {cmd_i.idx, 1'b0};
    sbit = 64'd1 << sh;
    rsum = sr_q + sbit;
    r33  = {1'b0, sr_q[31:0]};
    lx[0] = CW'(t11);
    ly[0] = CW'(t12);
    lx[1] = $signed({6'd0, sr_q[31:0]});
    ly[1] = CW'(tc);
    lx[2] = CW'(t33);
    ly[2] = CW'(t23);
    pz    = czero_q[1] ? '0 : cz_q[1];
    pneg  = -$signed({pz[31], pz});
    if (pneg > ONE_P) pitch_c = Q_ONE;
    else if (pneg < -ONE_P) pitch_c = -Q_ONE;
    else pitch_c = pneg[QUAT_W-1:0];
  end

  always_comb begin
    status_o.big = 1'b0;
    for (int j = 0; j < 4; j++) begin
      if (n_q[j] > QMAX_N || n_q[j] < -QMAX_N) status_o.big = 1'b1;
    end
    status_o.norm_zero = (s_q == '0);
  end

  // Configuration, attitude state and multiplier tag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      q_q[0]  <= Q_ONE;
      q_q[1]  <= '0;
      q_q[2]  <= '0;
      q_q[3]  <= '0;
      pvld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      pvld_q <= cmd_i.mul_en;
      if (cmd_i.op == OP_IDENT) begin
        q_q[0] <= Q_ONE;
        q_q[1] <= '0;
        q_q[2] <= '0;
        q_q[3] <= '0;
      end else if (cmd_i.op == OP_QSTORE) begin
        for (int j = 0; j < 4; j++) begin
          q_q[j] <= n_q[j][NW-1] ? -$signed({1'b0, quo_q[j]}) : $signed({1'b0, quo_q[j]});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
    pop_q  <= cmd_i.op;
    pidx_q <= cmd_i.idx;

    if (cmd_i.op == OP_LOAD) begin
      rate_q[0] <= rate_x_i;
      rate_q[1] <= rate_y_i;
      rate_q[2] <= rate_z_i;
      for (int j = 0; j < 4; j++) n_q[j] <= NW'(q_q[j]);
      s_q <= '0;
    end else if (cmd_i.op == OP_HALVE) begin
      for (int j = 0; j < 4; j++) n_q[j] <= n_q[j] >>> 1;
    end

    if (pvld_q) begin
      case (pop_q)
        OP_GYRO: begin
          if (gsh > QMAX_P) h_q[pidx_q[1:0]] <= QMAX_P[QUAT_W-1:0];
          else if (gsh < -QMAX_P) h_q[pidx_q[1:0]] <= -QMAX_P[QUAT_W-1:0];
          else h_q[pidx_q[1:0]] <= gsh[QUAT_W-1:0];
        end
        OP_UPD:   n_q[utgt] <= uneg ? n_q[utgt] - qm : n_q[utgt] + qm;
        OP_SQSUM: s_q <= s_q + prod_q[SW-1:0];
        OP_DCM:   p_q[pidx_q[3:0]] <= qsh[QUAT_W-1:0];
        OP_TSQ:   src2_q <= ONE_SQ - prod_q[SW-1:0];
        default:  ;
      endcase
    end

    case (cmd_i.op)
      OP_SQRT_INIT: begin
        sv_q <= cmd_i.sel ? src2_q : s_q;
        sr_q <= '0;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= rsum) begin
          sv_q <= sv_q - rsum;
          sr_q <= (sr_q >> 1) + sbit;
        end else begin
          sr_q <= sr_q >> 1;
        end
      end
      OP_DIV_INIT: begin
        for (int j = 0; j < 4; j++) begin
          rem_q[j] <= n_q[j][NW-1] ? 33'(-n_q[j]) : 33'(n_q[j]);
          quo_q[j] <= '0;
        end
      end
      OP_DIV_STEP: begin
        for (int j = 0; j < 4; j++) begin
          logic [32:0] cur;
          cur = (cmd_i.idx == '0) ? rem_q[j] : {rem_q[j][31:0], 1'b0};
          if (cur >= r33) begin
            rem_q[j] <= cur - r33;
            quo_q[j] <= {quo_q[j][29:0], 1'b1};
          end else begin
            rem_q[j] <= cur;
            quo_q[j] <= {quo_q[j][29:0], 1'b0};
          end
        end
      end
      OP_CORD_INIT: begin
        for (int l = 0; l < 3; l++) begin
          czero_q[l] <= (lx[l] == '0) && (ly[l] == '0);
          if (lx[l] < 0) begin
            cx_q[l] <= -lx[l];
            cy_q[l] <= -ly[l];
            cz_q[l] <= 32'h8000_0000;
          end else begin
            cx_q[l] <= lx[l];
            cy_q[l] <= ly[l];
            cz_q[l] <= '0;
          end
        end
      end
      OP_CORD_STEP: begin
        for (int l = 0; l < 3; l++) begin
          if (cy_q[l] > 0) begin
            cx_q[l] <= cx_q[l] + (cy_q[l] >>> cmd_i.idx);
            cy_q[l] <= cy_q[l] - (cx_q[l] >>> cmd_i.idx);
            cz_q[l] <= cz_q[l] + atan_lut(cmd_i.idx);
          end else begin
            cx_q[l] <= cx_q[l] - (cy_q[l] >>> cmd_i.idx);
            cy_q[l] <= cy_q[l] + (cx_q[l] >>> cmd_i.idx);
            cz_q[l] <= cz_q[l] - atan_lut(cmd_i.idx);
          end
        end
      end
      OP_OUT: begin
        quat_w_o      <= q_q[0];
        quat_x_o      <= q_q[1];
        quat_y_o      <= q_q[2];
        quat_z_o      <= q_q[3];
        yaw_angle_o   <= czero_q[0] ? '0 : $signed(cz_q[0]);
        roll_angle_o  <= czero_q[2] ? '0 : $signed(cz_q[2]);
        pitch_angle_o <= pitch_c;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### rtl/quaternion_attitude_update.sv
// Top level of the gyro-driven attitude quaternion integrator with Euler angle readout.
// An input transfer is taken only in the idle state, so a new sample is not accepted
// until the previous one has passed every phase; halving steps are added when the
// update overflows, and a zero norm skips the square root and the divide. The shared
// multiplier, the bit-serial square root (twice 32 steps), the 31-step divider and the
// 31-step CORDIC set the processing time of each sample.
// Reset: the attitude returns to identity and gyro_scale to 216930; no result pending.
`default_nettype none
module quaternion_attitude_update import qau_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SCALE_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [GYRO_W-1:0]  rate_x_i,
  input  logic signed [GYRO_W-1:0]  rate_y_i,
  input  logic signed [GYRO_W-1:0]  rate_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [QUAT_W-1:0]  quat_w_o,
  output logic signed [QUAT_W-1:0]  quat_x_o,
  output logic signed [QUAT_W-1:0]  quat_y_o,
  output logic signed [QUAT_W-1:0]  quat_z_o,
  output logic signed [ANGLE_W-1:0] yaw_angle_o,
  output logic signed [ANGLE_W-1:0] pitch_angle_o,
  output logic signed [ANGLE_W-1:0] roll_angle_o
);

  // The controller steps through the phases of one update: scaling of the rates,
  // the twelve update products, halving on overflow, the sum of squares, the
  // square root and four-lane divide for renormalisation, the direction cosine
  // products, the pitch cosine root and finally three CORDIC lanes in parallel.
  dp_cmd_t    cmd;
  dp_status_t status;

  qau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the attitude state, the configuration register and the
  // output register; a finished result waits there while a new transfer is taken.
  qau_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rate_x_i      (rate_x_i),
    .rate_y_i      (rate_y_i),
    .rate_z_i      (rate_z_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .quat_w_o      (quat_w_o),
    .quat_x_o      (quat_x_o),
    .quat_y_o      (quat_y_o),
    .quat_z_o      (quat_z_o),
    .yaw_angle_o   (yaw_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .roll_angle_o  (roll_angle_o)
  );

endmodule
`default_nettype wire

### tb/quaternion_attitude_update_checker.sv
// Checker for the attitude integrator: watches both channels, predicts results and compares.
`timescale 1ns / 1ps
module quaternion_attitude_update_checker import qau_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [SCALE_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [GYRO_W-1:0]  rate_x_i,
  input  logic signed [GYRO_W-1:0]  rate_y_i,
  input  logic signed [GYRO_W-1:0]  rate_z_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [QUAT_W-1:0]  quat_w_i,
  input  logic signed [QUAT_W-1:0]  quat_x_i,
  input  logic signed [QUAT_W-1:0]  quat_y_i,
  input  logic signed [QUAT_W-1:0]  quat_z_i,
  input  logic signed [ANGLE_W-1:0] yaw_angle_i,
  input  logic signed [ANGLE_W-1:0] pitch_angle_i,
  input  logic signed [ANGLE_W-1:0] roll_angle_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        result_count_o
);

  typedef struct packed {
    logic [QUAT_W-1:0]  qw;
    logic [QUAT_W-1:0]  qx;
    logic [QUAT_W-1:0]  qy;
    logic [QUAT_W-1:0]  qz;
    logic [ANGLE_W-1:0] yaw;
    logic [ANGLE_W-1:0] pitch;
    logic [ANGLE_W-1:0] roll;
  } attitude_t;

  localparam longint ONE_Q = longint'(1) << QF;
  localparam longint MAX_Q = (longint'(1) << (QUAT_W - 1)) - 1;

  localparam logic [31:0] ARCTAN [31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544,
    32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
    32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81, 32'd41, 32'd20, 32'd10,
    32'd5, 32'd3, 32'd1, 32'd1
  };

  longint            att_q [4];
  logic [SCALE_W-1:0] scale_q;
  attitude_t         expected_q [$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Fixed-point product, floored back to the quaternion format.
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> QF;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring rotation: binary angle of the point (x, y), pi at 2^31.
  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] z;
    longint xs;
    longint ys;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN[i];
      end
    end
    return z;
  endfunction

  // Advances the stored attitude by one gyro sample and forms the Euler readout.
  function automatic attitude_t integrate(logic signed [GYRO_W-1:0] rx,
                                          logic signed [GYRO_W-1:0] ry,
                                          logic signed [GYRO_W-1:0] rz);
    attitude_t res;
    longint h [3];
    longint n [4];
    longint unsigned sq;
    longint unsigned r;
    longint q00, q01, q02, q03, q11, q12, q13, q22, q23, q33;
    longint t11, t12, t13, t23, t33, tc, p;
    logic [31:0] a;
    bit big;
    h[0] = clip((longint'(rx) * longint'(scale_q)) >>> (33 - QF), -MAX_Q, MAX_Q);
    h[1] = clip((longint'(ry) * longint'(scale_q)) >>> (33 - QF), -MAX_Q, MAX_Q);
    h[2] = clip((longint'(rz) * longint'(scale_q)) >>> (33 - QF), -MAX_Q, MAX_Q);
    n[0] = att_q[0] - fx_mul(att_q[1], h[0]) - fx_mul(att_q[2], h[1])
           - fx_mul(att_q[3], h[2]);
    n[1] = att_q[1] + fx_mul(att_q[0], h[0]) + fx_mul(att_q[2], h[2])
           - fx_mul(att_q[3], h[1]);
    n[2] = att_q[2] + fx_mul(att_q[0], h[1]) - fx_mul(att_q[1], h[2])
           + fx_mul(att_q[3], h[0]);
    n[3] = att_q[3] + fx_mul(att_q[0], h[2]) + fx_mul(att_q[1], h[1])
           - fx_mul(att_q[2], h[0]);
    // Overflowing updates are halved together, which keeps the direction.
    do begin
      big = 0;
      for (int i = 0; i < 4; i++) if (n[i] > MAX_Q || n[i] < -MAX_Q) big = 1;
      if (big) for (int i = 0; i < 4; i++) n[i] = n[i] >>> 1;
    end while (big);
    sq = 0;
    for (int i = 0; i < 4; i++) sq = sq + longint'(unsigned'(n[i] * n[i]));
    r = int_sqrt(sq);
    if (r == 0) begin
      att_q[0] = ONE_Q;
      for (int i = 1; i < 4; i++) att_q[i] = 0;
    end else begin
      for (int i = 0; i < 4; i++) att_q[i] = clip((n[i] * ONE_Q) / longint'(r), -ONE_Q, ONE_Q);
    end
    q00 = fx_mul(att_q[0], att_q[0]); q01 = fx_mul(att_q[0], att_q[1]);
    q02 = fx_mul(att_q[0], att_q[2]); q03 = fx_mul(att_q[0], att_q[3]);
    q11 = fx_mul(att_q[1], att_q[1]); q12 = fx_mul(att_q[1], att_q[2]);
    q13 = fx_mul(att_q[1], att_q[3]); q22 = fx_mul(att_q[2], att_q[2]);
    q23 = fx_mul(att_q[2], att_q[3]); q33 = fx_mul(att_q[3], att_q[3]);
    t11 = q00 + q11 - q22 - q33;
    t12 = 2 * (q12 + q03);
    t13 = 2 * (q13 - q02);
    t23 = 2 * (q23 + q01);
    t33 = q00 - q11 - q22 + q33;
    tc = clip(t13, -ONE_Q, ONE_Q);
    a = vector_angle(tc, longint'(int_sqrt(unsigned'(ONE_Q * ONE_Q - tc * tc))));
    p = -longint'(signed'(a));
    p = clip(p, -(longint'(1) << 30), longint'(1) << 30);
    res.qw    = att_q[0][QUAT_W-1:0];
    res.qx    = att_q[1][QUAT_W-1:0];
    res.qy    = att_q[2][QUAT_W-1:0];
    res.qz    = att_q[3][QUAT_W-1:0];
    res.yaw   = vector_angle(t12, t11);
    res.pitch = p[31:0];
    res.roll  = vector_angle(t23, t33);
    return res;
  endfunction

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("MISMATCH result %0d %s: expected %0d, got %0d", result_count_o, fname,
                 $signed(exp_v), $signed(act_v));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    attitude_t e;
    if (!rst_ni) begin
      att_q[0] = ONE_Q;
      for (int i = 1; i < 4; i++) att_q[i] = 0;
      scale_q = SCALE_RESET;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) scale_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) expected_q.push_back(integrate(rate_x_i, rate_y_i, rate_z_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("UNEXPECTED result with nothing outstanding");
        end else begin
          e = expected_q.pop_front();
          check_field("quat_w", e.qw, quat_w_i);
          check_field("quat_x", e.qx, quat_x_i);
          check_field("quat_y", e.qy, quat_y_i);
          check_field("quat_z", e.qz, quat_z_i);
          check_field("yaw", e.yaw, yaw_angle_i);
          check_field("pitch", e.pitch, pitch_angle_i);
          check_field("roll", e.roll, roll_angle_i);
        end
        result_count_o++;
      end
      pending_o = expected_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    result_count_o = 0;
  end

endmodule

### tb/quaternion_attitude_update_tb.sv
// Testbench top for the attitude integrator: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module quaternion_attitude_update_tb;
  import qau_pkg::*;

  // The run is aborted if it goes on this long; even with the longest gaps and
  // stalls on every sample a correct run needs well under a quarter of it.
  localparam int CYCLE_LIMIT = 5_000_000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [SCALE_W-1:0]        cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [GYRO_W-1:0]  rate_x_i;
  logic signed [GYRO_W-1:0]  rate_y_i;
  logic signed [GYRO_W-1:0]  rate_z_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [QUAT_W-1:0]  quat_w_o;
  logic signed [QUAT_W-1:0]  quat_x_o;
  logic signed [QUAT_W-1:0]  quat_y_o;
  logic signed [QUAT_W-1:0]  quat_z_o;
  logic signed [ANGLE_W-1:0] yaw_angle_o;
  logic signed [ANGLE_W-1:0] pitch_angle_o;
  logic signed [ANGLE_W-1:0] roll_angle_o;

  int fail_count;
  int pending;
  int result_count;
  int cycle_count;
  int sample_count;
  int scale_settings;
  bit hold_request;

  quaternion_attitude_update dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_ready_o,
    .rate_x_i, .rate_y_i, .rate_z_i, .out_valid_o, .out_ready_i,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o,
    .yaw_angle_o, .pitch_angle_o, .roll_angle_o
  );

  quaternion_attitude_update_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .rate_x_i, .rate_y_i, .rate_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .quat_w_i(quat_w_o), .quat_x_i(quat_x_o), .quat_y_i(quat_y_o), .quat_z_i(quat_z_o),
    .yaw_angle_i(yaw_angle_o), .pitch_angle_i(pitch_angle_o), .roll_angle_i(roll_angle_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake must not let the run go on for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("quaternion_attitude_update verification failed");
      $finish;
    end
  end

  // Receiver side. Ready is held at a random level for a random number of cycles;
  // most stretches are short, a few stall for a long while. When the sender asks
  // for it, ready is held low for a long stretch so that the block backs up and
  // stops taking new transfers on its input.
  initial begin
    int run_len;
    int hold_cycles;
    out_ready_i = 1'b0;
    run_len = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 1500) begin
          @(negedge clk_i);
          hold_cycles++;
        end
        hold_request = 1'b0;
        out_ready_i <= 1'b1;
        run_len = 0;
      end else if (run_len > 0) begin
        run_len--;
      end else if ($urandom_range(0, 3) != 0) begin
        out_ready_i <= 1'b1;
        run_len = $urandom_range(0, 30);
      end else begin
        out_ready_i <= 1'b0;
        run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200) : $urandom_range(0, 4);
      end
    end
  end

  // Offers one gyro sample and waits for its transfer. A random gap comes first;
  // with no gap, valid stays high straight into the next sample.
  task automatic send_sample(logic signed [GYRO_W-1:0] rx, logic signed [GYRO_W-1:0] ry,
                             logic signed [GYRO_W-1:0] rz);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 5);
    else gap = $urandom_range(20, 150);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rate_x_i   <= rx;
    rate_y_i   <= ry;
    rate_z_i   <= rz;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sample_count++;
  endtask

  // Mostly small turn rates so that the attitude drifts smoothly, with some
  // full-range counts mixed in.
  task automatic send_random(int count);
    logic signed [GYRO_W-1:0] r [3];
    for (int k = 0; k < count; k++) begin
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(0, 3) == 0) r[a] = GYRO_W'($urandom);
        else r[a] = GYRO_W'($signed($urandom_range(0, 4000)) - 2000);
      end
      send_sample(r[0], r[1], r[2]);
    end
  endtask

  // Writes the scale only once the block has returned every result.
  task automatic set_scale(logic [SCALE_W-1:0] value);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    scale_settings++;
  endtask

  initial begin
    cycle_count    = 0;
    sample_count   = 0;
    scale_settings = 0;
    hold_request   = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rate_x_i    = '0;
    rate_y_i    = '0;
    rate_z_i    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part at the reset scale: no rotation, each axis at both
    // extremes, all axes together and mixed signs.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0, 16'sd0);
    send_sample(-16'sd32768, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd32767);
    send_sample(16'sd0, 16'sd0, -16'sd32768);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    send_sample(16'sd1, -16'sd1, 16'sd1);

    // Zero scale: the attitude must not move.
    set_scale('0);
    send_sample(16'sd32767, -16'sd32768, 16'sd12345);
    send_sample(-16'sd1, 16'sd1, -16'sd1);

    // Largest scale: half angles saturate, the update overflows and is halved,
    // and pitch is driven towards its limit.
    set_scale('1);
    send_sample(16'sd32767, 16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
    send_sample(16'sd0, 16'sd32767, 16'sd0);
    send_sample(16'sd0, -16'sd32768, 16'sd0);
    send_sample(16'sd20000, -16'sd9000, 16'sd3);
    send_random(60);

    // Coarse scale so that pitch reaches the asin limit and yaw wraps through pi.
    set_scale(32'd216930 * 32'd2000);
    send_random(250);

    set_scale(SCALE_RESET);
    send_random(300);

    // Long receiver stall while samples keep being offered.
    hold_request = 1'b1;
    send_random(300);

    // Pause until the pipeline has drained completely, then carry on.
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    set_scale($urandom);
    send_random(400);

    set_scale(32'd216930 * 32'd40);
    send_random(400);

    set_scale(32'd1);
    send_random(200);

    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (400) @(posedge clk_i);

    $display("Sent %0d gyro samples under %0d scale settings; %0d results checked.",
             sample_count, scale_settings, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("quaternion_attitude_update verification clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("quaternion_attitude_update verification failed");
    end
    $finish;
  end

endmodule
